// ===== src/dq_pkg.sv =====
// Shared operation and status codes for the double-ended queue.
`default_nettype none
package dq_pkg;

   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int VALUE_BITS  = 32;

   typedef logic [FUNC_BITS-1:0]   func_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam func_type FUNC_PUSH_FRONT = 2'd0;
   localparam func_type FUNC_PUSH_BACK  = 2'd1;
   localparam func_type FUNC_POP_FRONT  = 2'd2;
   localparam func_type FUNC_POP_BACK   = 2'd3;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_POP_EMPTY = 2'd1;
   localparam status_type STATUS_PUSH_FULL = 2'd2;

endpackage
`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Double-ended queue of signed words held in a ring of DEPTH entries. Each request word
// carries one operation (push front, push back, pop front, pop back) and produces exactly
// one response word with the new front and back values (-1 when empty), the count and a
// status. Each word passes through three steps: on acceptance the pointers and count are
// updated and the ring is written, in the read state the ring's registered read ports take
// the front and back entries, and in the data state the response register is loaded once it
// is free. The response register lets the next request be accepted while a response still
// waits. Pops on an empty queue and pushes onto a full ring change nothing and are flagged.
`default_nettype none
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS    = $clog2(DEPTH + 1),
   localparam int REQ_BITS    = FUNC_BITS + VALUE_BITS,
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS    = 2 * VALUE_BITS + 1 + CNT_BITS + STATUS_BITS,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request fields from bit 0 up: func, element_value.
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // Response fields from bit 0 up: front_value, back_value, is_empty, entry_count,
   // op_status.
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [1:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   front_ff, front_in;
   logic [IDX_BITS-1:0]   back_ff, back_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff;

   func_type              req_func;
   logic [VALUE_BITS-1:0] req_value;
   logic                  req_take;
   logic                  rsp_load;

   logic [IDX_BITS-1:0]   front_prev, front_next, back_prev, back_next;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [WORD_BITS-1:0]  rd_front, rd_back;
   logic [VALUE_BITS-1:0] front_value, back_value;
   logic                  is_empty;

   assign req_func  = req_tdata[FUNC_BITS-1:0];
   assign req_value = req_tdata[FUNC_BITS +: VALUE_BITS];
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;

   assign wr_data = WORD_BITS'($signed(req_value));

   // Pointer and count update, done in the cycle the request word is accepted.
   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      if (req_take) begin
         status_in = STATUS_DONE;
         unique case (req_func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
               if (count_ff == FULL_CNT) begin
                  status_in = STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     back_in = front_ff;
                     wr_addr = front_ff;
                  end else if (req_func == FUNC_PUSH_FRONT) begin
                     front_in = front_prev;
                     wr_addr  = front_prev;
                  end else begin
                     back_in = back_next;
                     wr_addr = back_next;
                  end
               end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = STATUS_POP_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  // Removing the last entry leaves both pointers in place.
                  if (count_ff != CNT_BITS'(1)) begin
                     if (req_func == FUNC_POP_FRONT) begin
                        front_in = front_next;
                     end else begin
                        back_in = back_prev;
                     end
                  end
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   assign rsp_load = (state_ff == S_DATA) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_READ;
         S_READ:  state_in = S_DATA;
         S_DATA:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The ring is read every cycle at the current pointers; the words read during the
   // cycle after an update are the ones that reach the response register.
   dq_ring #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (front_ff),
      .rd_addr_b (back_ff),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   assign is_empty    = (count_ff == '0);
   assign front_value = is_empty ? '1 : VALUE_BITS'($signed(rd_front));
   assign back_value  = is_empty ? '1 : VALUE_BITS'($signed(rd_back));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         status_ff    <= STATUS_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {status_ff, count_ff, is_empty, back_value, front_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Number of entries spanned from front to back, inclusive, around the ring.
   logic [IDX_BITS:0] span;
   assign span = (back_ff >= front_ff)
                 ? ({1'b0, back_ff} - {1'b0, front_ff} + 1'b1)
                 : ({1'b0, back_ff} + (IDX_BITS + 1)'(DEPTH) - {1'b0, front_ff} + 1'b1);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count exceeds ring depth");

   a_span_matches_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ((IDX_BITS + 1)'(count_ff) == span))
      else $error("front and back pointers disagree with the entry count");

   a_pop_empty_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_take && count_ff == '0 &&
       (req_func == FUNC_POP_FRONT || req_func == FUNC_POP_BACK))
      |=> (count_ff == '0 && $stable(front_ff) && $stable(back_ff)))
      else $error("pop on empty queue changed state");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_READ && !req_tready))
      else $error("request accepted while previous word still in flight");

endmodule
`default_nettype wire

// ===== src/dq_ring.sv =====
// Ring storage: one write port and two registered read ports.
`default_nettype none
module dq_ring #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   parameter int IDX_BITS  = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IDX_BITS-1:0]  wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic [IDX_BITS-1:0]  rd_addr_a,
   input  wire logic [IDX_BITS-1:0]  rd_addr_b,
   output logic      [WORD_BITS-1:0] rd_data_a,
   output logic      [WORD_BITS-1:0] rd_data_b
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== dv/double_ended_queue_tb.sv =====
// Testbench for the double-ended queue: directed and random operations checked against a predictor.
`default_nettype none
module double_ended_queue_tb
   import dq_pkg::*;
();

   localparam int DEPTH        = 16;
   localparam int REQ_W        = 40;
   localparam int RSP_W        = 72;
   localparam int RANDOM_ITEMS = 700;
   localparam int PHASE_ITEMS  = 50;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [VALUE_BITS-1:0] front_value;
      logic signed [VALUE_BITS-1:0] back_value;
      logic                         is_empty;
      logic [4:0]                   entry_count;
      status_type                   op_status;
   } deque_view_type;

   class deque_scoreboard_type;
      logic [VALUE_BITS-1:0] ring[DEPTH];
      logic [3:0]            front_slot;
      logic [3:0]            back_slot;
      logic [4:0]            held;
      deque_view_type        awaited[$];
      int                    mismatches;

      function new();
         front_slot = '0;
         back_slot  = '0;
         held       = '0;
         mismatches = 0;
      endfunction

      // Applies one accepted operation to the predicted deque and queues the view it leaves.
      function void note_request(func_type op, logic [VALUE_BITS-1:0] value);
         deque_view_type v;
         v.op_status = STATUS_DONE;
         if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK) begin
            if (held >= DEPTH) begin
               v.op_status = STATUS_PUSH_FULL;
            end else begin
               if (held == 0) begin
                  back_slot = front_slot;
                  ring[front_slot] = value;
               end else if (op == FUNC_PUSH_FRONT) begin
                  front_slot = front_slot - 4'd1;
                  ring[front_slot] = value;
               end else begin
                  back_slot = back_slot + 4'd1;
                  ring[back_slot] = value;
               end
               held = held + 5'd1;
            end
         end else begin
            if (held == 0) begin
               v.op_status = STATUS_POP_EMPTY;
            end else begin
               held = held - 5'd1;
               // Popping the last entry leaves both indices where they are.
               if (held != 0) begin
                  if (op == FUNC_POP_FRONT) front_slot = front_slot + 4'd1;
                  else back_slot = back_slot - 4'd1;
               end
            end
         end
         v.is_empty    = (held == 0);
         v.entry_count = held;
         v.front_value = v.is_empty ? -32'sd1 : ring[front_slot];
         v.back_value  = v.is_empty ? -32'sd1 : ring[back_slot];
         awaited.push_back(v);
      endfunction

      function void check_response(logic [RSP_W-1:0] word);
         deque_view_type got;
         deque_view_type want;
         got.front_value = word[31:0];
         got.back_value  = word[63:32];
         got.is_empty    = word[64];
         got.entry_count = word[69:65];
         got.op_status   = word[71:70];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response word %h", word);
            return;
         end
         want = awaited.pop_front();
         if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
             got.is_empty !== want.is_empty || got.entry_count !== want.entry_count ||
             got.op_status !== want.op_status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response mismatch: front %h/%h back %h/%h empty %b/%b",
                        want.front_value, got.front_value, want.back_value, got.back_value,
                        want.is_empty, got.is_empty,
                        " count %0d/%0d status %0d/%0d (expected/actual)",
                        want.entry_count, got.entry_count, want.op_status, got.op_status);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   deque_scoreboard_type sb;
   bit                   quiet_mode    = 1'b0;
   int                   hold_requests = 0;

   always #5 clock = ~clock;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      unique case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(func_type op, logic [VALUE_BITS-1:0] value);
      int gap;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, value, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, value);
   endtask

   initial begin : response_side
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !quiet_mode && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int push_pct;
      int n;
      func_type op;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Pops on an empty deque, a stored -1, emptying and refilling from both ends.
      send_request(FUNC_POP_FRONT, 32'h1234_5678);
      send_request(FUNC_POP_BACK, 32'hffff_ffff);
      send_request(FUNC_PUSH_BACK, 32'hffff_ffff);
      send_request(FUNC_POP_FRONT, 32'h0);
      send_request(FUNC_PUSH_FRONT, 32'h7fff_ffff);
      send_request(FUNC_PUSH_BACK, 32'h8000_0000);
      send_request(FUNC_POP_BACK, 32'h0);
      send_request(FUNC_POP_FRONT, 32'h0);
      // Fill the ring, then push at both ends while it is full.
      for (int i = 0; i < DEPTH; i++)
         send_request(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_value());
      send_request(FUNC_PUSH_FRONT, 32'h5555_aaaa);
      send_request(FUNC_PUSH_BACK, 32'haaaa_5555);

      // Each phase leans toward pushes or pops so the count sweeps from empty to full.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         push_pct   = 10 + 20 * $urandom_range(0, 4);
         quiet_mode = ($urandom_range(0, 3) == 0);
         if (n == 2 * PHASE_ITEMS) begin
            // The receiver holds off for a long stretch while requests keep coming.
            quiet_mode = 1'b1;
            hold_requests++;
         end
         for (int k = 0; k < PHASE_ITEMS && n < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 99) < push_pct)
               op = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
            send_request(op, pick_value());
            n++;
         end
      end
      req_tvalid <= 1'b0;
      quiet_mode = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
